[hw/rtl/ipv4tap_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ipv4tap_pkg
// Shared types and constants for the IPv4 text address parser.
// ----------------------------------------------------------------------------
package ipv4tap_pkg;

    // parse phase codes
    localparam logic [2:0] PH_START  = 3'd0;
    localparam logic [2:0] PH_ZERO   = 3'd1;
    localparam logic [2:0] PH_DIGITS = 3'd2;
    localparam logic [2:0] PH_SKIP   = 3'd3;
    localparam logic [2:0] PH_REJECT = 3'd4;

    // radix codes (code 3 behaves as decimal)
    localparam logic [1:0] RX_DEC = 2'd0;
    localparam logic [1:0] RX_OCT = 2'd1;
    localparam logic [1:0] RX_HEX = 2'd2;

    // character codes
    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_D0    = 8'h30;
    localparam logic [7:0] CH_D9    = 8'h39;
    localparam logic [7:0] CH_UA    = 8'h41;
    localparam logic [7:0] CH_UF    = 8'h46;
    localparam logic [7:0] CH_UX    = 8'h58;
    localparam logic [7:0] CH_LA    = 8'h61;
    localparam logic [7:0] CH_LF    = 8'h66;
    localparam logic [7:0] CH_LX    = 8'h78;

    // range limits of the last part
    localparam logic [31:0] LIM_24 = 32'h00FF_FFFF;
    localparam logic [31:0] LIM_16 = 32'h0000_FFFF;
    localparam logic [31:0] LIM_8  = 32'h0000_00FF;

    typedef struct packed {
        logic [2:0]  phase;
        logic [1:0]  radix;
        logic [31:0] accum;
        logic        wide;
        logic [1:0]  part_count;
    } parse_state_t;

    localparam parse_state_t STATE_RESET = '{
        phase:      PH_START,
        radix:      RX_DEC,
        accum:      32'd0,
        wide:       1'b0,
        part_count: 2'd0
    };

    typedef struct packed {
        logic       en;
        logic [1:0] idx;
        logic [7:0] data;
    } store_wr_t;

endpackage : ipv4tap_pkg
`default_nettype wire

[hw/rtl/ipv4_text_address_parser_unit.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ipv4_text_address_parser_unit
// Parses dotted IPv4 address text (hex, octal, decimal parts) one character
// per item and returns ok plus the 32-bit host-order address on NUL.
// ----------------------------------------------------------------------------
//  channel  | handshake             | payload
//  ---------+-----------------------+--------------------------
//  input    | in_valid / in_ready   | ch[7:0]
//  result   | out_valid / out_ready | ok, address[31:0]
//
//  One character per cycle unless a result is held; the accumulator shift-add
//  sits between the input register and the result register. The result of a
//  NUL character is registered from the input register. Characters other
//  than NUL give no result. A held result stalls the input register; the
//  input side takes an item whenever that register is free or moving on.
//  Reset returns to an empty address with no part open.
// ----------------------------------------------------------------------------
module ipv4_text_address_parser_unit (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [7:0]  ch,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic             ok,
    output logic [31:0]      address
);
    import ipv4tap_pkg::*;

    logic         in_valid_reg;
    logic [7:0]   ch_reg;
    parse_state_t state_reg;
    parse_state_t state_next;
    logic [7:0]   part_store_reg [0:2];
    store_wr_t    store_wr;
    logic         step_emit;
    logic         step_ok;
    logic [31:0]  step_address;
    logic         advance;
    logic         out_valid_reg;
    logic         ok_reg;
    logic [31:0]  address_reg;

    assign advance  = in_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !in_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (in_ready)
            in_valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
            ch_reg <= ch;
    end

    ipv4tap_step u_step (
        .ch       (ch_reg),
        .st       (state_reg),
        .part0    (part_store_reg[0]),
        .part1    (part_store_reg[1]),
        .part2    (part_store_reg[2]),
        .nxt      (state_next),
        .store_wr (store_wr),
        .emit     (step_emit),
        .ok       (step_ok),
        .address  (step_address)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= STATE_RESET;
        else if (advance)
            state_reg <= state_next;
    end

    // closed parts; only entries below part_count are ever read
    always_ff @(posedge clk)
    begin
        if (advance && store_wr.en)
            part_store_reg[store_wr.idx] <= store_wr.data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (advance && step_emit)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (advance && step_emit)
        begin
            ok_reg      <= step_ok;
            address_reg <= step_address;
        end
    end

    assign out_valid = out_valid_reg;
    assign ok        = ok_reg;
    assign address   = address_reg;

    // a rejected text always reports a zero address
    a_reject_zero : assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !ok_reg |-> address_reg == 32'd0)
        else $error("rejected item carries nonzero address");

    // every result clears the parser for the next address
    a_clear_after_emit : assert property (@(posedge clk) disable iff (!rst_n)
        advance && step_emit |=> state_reg.phase == PH_START
            && state_reg.part_count == 2'd0 && state_reg.accum == 32'd0
            && !state_reg.wide)
        else $error("parser state not cleared after result");

    // phase never leaves its defined codes
    a_phase_range : assert property (@(posedge clk) disable iff (!rst_n)
        state_reg.phase <= PH_REJECT)
        else $error("parse phase out of range");

    // input stalls only while a character waits behind a held result
    a_stall_cause : assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> in_valid_reg && out_valid_reg && !out_ready)
        else $error("input stalled without a held result");

endmodule : ipv4_text_address_parser_unit
`default_nettype wire

[hw/rtl/ipv4tap_mac.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ipv4tap_mac
// Digit decode and constant-radix shift-add of the part accumulator.
// ----------------------------------------------------------------------------
module ipv4tap_mac (
    input  wire logic [7:0]  ch,
    input  wire logic [1:0]  radix,
    input  wire logic [31:0] accum,
    output logic             is_digit,
    output logic [31:0]      value,
    output logic             overflow
);
    import ipv4tap_pkg::*;

    logic [3:0]  digit;
    logic [35:0] acc_ext;
    logic [35:0] scaled;
    logic [35:0] sum;

    always_comb
    begin
        is_digit = 1'b0;
        digit    = 4'd0;
        if (ch >= CH_D0 && ch <= CH_D9)
        begin
            is_digit = 1'b1;
            digit    = 4'(ch - CH_D0);
        end
        else if (radix == RX_HEX && ch >= CH_LA && ch <= CH_LF)
        begin
            is_digit = 1'b1;
            digit    = 4'(ch - CH_LA + 8'd10);
        end
        else if (radix == RX_HEX && ch >= CH_UA && ch <= CH_UF)
        begin
            is_digit = 1'b1;
            digit    = 4'(ch - CH_UA + 8'd10);
        end
    end

    assign acc_ext = {4'd0, accum};

    always_comb
    begin
        unique case (radix)
            RX_OCT:  scaled = acc_ext << 3;
            RX_HEX:  scaled = acc_ext << 4;
            default: scaled = (acc_ext << 3) + (acc_ext << 1);
        endcase
    end

    assign sum      = scaled + {32'd0, digit};
    assign value    = sum[31:0];
    assign overflow = |sum[35:32];

endmodule : ipv4tap_mac
`default_nettype wire

[hw/rtl/ipv4tap_step.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ipv4tap_step
// Next-state and result logic for one character of the address text.
// ----------------------------------------------------------------------------
module ipv4tap_step (
    input  wire logic [7:0]                ch,
    input  wire ipv4tap_pkg::parse_state_t st,
    input  wire logic [7:0]                part0,
    input  wire logic [7:0]                part1,
    input  wire logic [7:0]                part2,
    output ipv4tap_pkg::parse_state_t      nxt,
    output ipv4tap_pkg::store_wr_t         store_wr,
    output logic                           emit,
    output logic                           ok,
    output logic [31:0]                    address
);
    import ipv4tap_pkg::*;

    logic [1:0]  dig_radix;
    logic        mac_digit;
    logic [31:0] mac_value;
    logic        mac_ovf;
    logic        is_nul;
    logic        is_x;
    logic        is_space;
    logic        take_digits;
    logic        finish_now;
    logic        reject_now;
    logic        fin_ok;
    logic [31:0] fin_addr;

    assign is_nul   = (ch == CH_NUL);
    assign is_x     = (ch == CH_LX) || (ch == CH_UX);
    assign is_space = (ch == CH_SPACE) || (ch >= CH_TAB && ch <= CH_CR);

    // radix that applies to a digit in this cycle
    always_comb
    begin
        if (st.phase == PH_START)
            dig_radix = RX_DEC;
        else if (st.phase == PH_ZERO)
            dig_radix = RX_OCT;
        else
            dig_radix = st.radix;
    end

    ipv4tap_mac u_mac (
        .ch       (ch),
        .radix    (dig_radix),
        .accum    (st.accum),
        .is_digit (mac_digit),
        .value    (mac_value),
        .overflow (mac_ovf)
    );

    // judgment of the whole text at its end
    always_comb
    begin
        unique case (st.part_count)
            2'd0:
            begin
                fin_ok   = 1'b1;
                fin_addr = st.accum;
            end
            2'd1:
            begin
                fin_ok   = !(st.wide || st.accum > LIM_24);
                fin_addr = {part0, st.accum[23:0]};
            end
            2'd2:
            begin
                fin_ok   = !(st.wide || st.accum > LIM_16);
                fin_addr = {part0, part1, st.accum[15:0]};
            end
            default:
            begin
                fin_ok   = !(st.wide || st.accum > LIM_8);
                fin_addr = {part0, part1, part2, st.accum[7:0]};
            end
        endcase
    end

    always_comb
    begin
        nxt           = st;
        store_wr.en   = 1'b0;
        store_wr.idx  = st.part_count;
        store_wr.data = st.accum[7:0];
        emit          = 1'b0;
        ok            = 1'b0;
        address       = 32'd0;
        take_digits   = 1'b0;
        finish_now    = 1'b0;
        reject_now    = 1'b0;

        unique case (st.phase)
            PH_START:
            begin
                if (ch == CH_D0)
                begin
                    nxt.radix = RX_OCT;
                    nxt.phase = PH_ZERO;
                end
                else
                begin
                    nxt.radix   = RX_DEC;
                    nxt.phase   = PH_DIGITS;
                    take_digits = 1'b1;
                end
            end
            PH_ZERO:
            begin
                nxt.phase = PH_DIGITS;
                if (is_x)
                    nxt.radix = RX_HEX;
                else
                begin
                    nxt.radix   = RX_OCT;
                    take_digits = 1'b1;
                end
            end
            PH_DIGITS:
            begin
                take_digits = 1'b1;
            end
            PH_SKIP:
            begin
                finish_now = is_nul;
            end
            default:
            begin
                reject_now = is_nul;
            end
        endcase

        if (take_digits)
        begin
            priority if (mac_digit)
            begin
                nxt.accum = mac_value;
                nxt.wide  = st.wide | mac_ovf;
            end
            else if (is_nul)
                finish_now = 1'b1;
            else if (ch == CH_DOT)
            begin
                if (st.part_count == 2'd3 || st.wide || st.accum > LIM_8)
                    nxt.phase = PH_REJECT;
                else
                begin
                    store_wr.en    = 1'b1;
                    nxt.phase      = PH_START;
                    nxt.radix      = RX_DEC;
                    nxt.accum      = 32'd0;
                    nxt.wide       = 1'b0;
                    nxt.part_count = st.part_count + 2'd1;
                end
            end
            else
                nxt.phase = is_space ? PH_SKIP : PH_REJECT;
        end

        if (finish_now)
        begin
            emit    = 1'b1;
            ok      = fin_ok;
            address = fin_ok ? fin_addr : 32'd0;
            nxt     = STATE_RESET;
        end
        else if (reject_now)
        begin
            emit = 1'b1;
            nxt  = STATE_RESET;
        end
    end

endmodule : ipv4tap_step
`default_nettype wire

[verif/ipv4_text_address_parser_unit_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ipv4_text_address_parser_unit_tb
// Feeds address text into the parser one character per item. The texts are
// directed corner cases first, then random dotted addresses in decimal, octal
// and hex, plus broken and noisy text. A scoreboard keeps its own model of
// the parse state, predicts the ok/address result on every NUL, and checks
// each result in order. The sender works in bursts and the receiver stalls.
// ----------------------------------------------------------------------------
module ipv4_text_address_parser_unit_tb;
    import ipv4tap_pkg::*;

    localparam int TOTAL_CHARS = 1080;
    localparam int STALL_LIMIT = 1000;

    typedef struct packed {
        logic        ok;
        logic [31:0] address;
    } parse_result_t;

    class addr_text_scoreboard;
        logic [2:0]    phase;
        logic [1:0]    radix;
        logic [31:0]   accum;
        logic          wide;
        logic [1:0]    part_count;
        logic [7:0]    part_lo [3];
        parse_result_t expected_addrs [$];
        int            errors;

        function new();
            errors = 0;
            clear_text();
        endfunction

        function void clear_part();
            phase = PH_START;
            radix = RX_DEC;
            accum = 32'd0;
            wide  = 1'b0;
        endfunction

        function void clear_text();
            clear_part();
            part_count = 2'd0;
            foreach (part_lo[i])
                part_lo[i] = 8'd0;
        endfunction

        function void push_result(logic good, logic [31:0] value);
            parse_result_t r;
            r.ok      = good;
            r.address = good ? value : 32'd0;
            expected_addrs.push_back(r);
            clear_text();
        endfunction

        function void add_digit(logic [7:0] d);
            logic [63:0] base;
            logic [63:0] prod;
            base = (radix == RX_OCT) ? 64'd8 : (radix == RX_HEX) ? 64'd16 : 64'd10;
            prod = {32'd0, accum} * base + {56'd0, d};
            if (prod[63:32] != 32'd0)
                wide = 1'b1;
            accum = prod[31:0];
        endfunction

        // last part gets the range left over by the dotted parts
        function void close_text();
            logic        good;
            logic [31:0] value;
            case (part_count)
                2'd0:
                begin
                    good  = 1'b1;
                    value = accum;
                end
                2'd1:
                begin
                    good  = !wide && accum <= LIM_24;
                    value = accum | {part_lo[0], 24'd0};
                end
                2'd2:
                begin
                    good  = !wide && accum <= LIM_16;
                    value = accum | {part_lo[0], part_lo[1], 16'd0};
                end
                default:
                begin
                    good  = !wide && accum <= LIM_8;
                    value = accum | {part_lo[0], part_lo[1], part_lo[2], 8'd0};
                end
            endcase
            push_result(good, value);
        endfunction

        function void scan_digit(logic [7:0] c);
            if (c >= CH_D0 && c <= CH_D9)
                add_digit(c - CH_D0);
            else if (radix == RX_HEX && c >= CH_LA && c <= CH_LF)
                add_digit(c - CH_LA + 8'd10);
            else if (radix == RX_HEX && c >= CH_UA && c <= CH_UF)
                add_digit(c - CH_UA + 8'd10);
            else if (c == CH_NUL)
                close_text();
            else if (c == CH_DOT)
            begin
                if (part_count == 2'd3 || wide || accum > LIM_8)
                    phase = PH_REJECT;
                else
                begin
                    part_lo[part_count] = accum[7:0];
                    part_count = part_count + 2'd1;
                    clear_part();
                end
            end
            else if (c == CH_SPACE || (c >= CH_TAB && c <= CH_CR))
                phase = PH_SKIP;
            else
                phase = PH_REJECT;
        endfunction

        function void note_char(logic [7:0] c);
            case (phase)
                PH_START:
                begin
                    if (c == CH_D0)
                    begin
                        radix = RX_OCT;
                        phase = PH_ZERO;
                    end
                    else
                    begin
                        radix = RX_DEC;
                        phase = PH_DIGITS;
                        scan_digit(c);
                    end
                end
                PH_ZERO:
                begin
                    phase = PH_DIGITS;
                    if (c == CH_LX || c == CH_UX)
                        radix = RX_HEX;
                    else
                    begin
                        radix = RX_OCT;
                        scan_digit(c);
                    end
                end
                PH_DIGITS:
                    scan_digit(c);
                PH_SKIP:
                    if (c == CH_NUL)
                        close_text();
                default:
                    if (c == CH_NUL)
                        push_result(1'b0, 32'd0);
            endcase
        endfunction

        task report(string what);
            $display("[%0t] mismatch: %s", $realtime, what);
            errors++;
        endtask

        task check_result(logic ok_seen, logic [31:0] addr_seen);
            parse_result_t want;
            if (expected_addrs.size() == 0)
            begin
                report($sformatf("unexpected result ok=%0b address=%08h", ok_seen, addr_seen));
                return;
            end
            want = expected_addrs.pop_front();
            if (ok_seen !== want.ok)
                report($sformatf("ok=%0b, want %0b", ok_seen, want.ok));
            if (addr_seen !== want.address)
                report($sformatf("address=%08h, want %08h", addr_seen, want.address));
        endtask
    endclass

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic [7:0]  ch;
    logic        out_valid;
    logic        out_ready;
    logic        ok;
    logic [31:0] address;

    addr_text_scoreboard sb = new();

    logic [7:0]  text_q [$];
    int          chars_sent;
    int          burst_left;
    int          idle_cycles;
    int          ready_window;
    int          ready_mode;
    logic [15:0] ready_pat;

    ipv4_text_address_parser_unit DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .ch        (ch),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .ok        (ok),
        .address   (address)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #5 clk = ~clk;

    // receiver: windows of always-ready and of a rotating stall pattern
    initial
    begin
        out_ready    = 1'b0;
        ready_window = 0;
        ready_mode   = 0;
        ready_pat    = 16'h0001;
    end

    always @(negedge clk)
    begin
        if (ready_window == 0)
        begin
            ready_window = $urandom_range(30, 200);
            ready_mode   = $urandom_range(0, 2);
            ready_pat    = 16'($urandom) | 16'h0001;
        end
        out_ready <= (ready_mode == 0) ? 1'b1 : ready_pat[0];
        ready_pat = {ready_pat[0], ready_pat[15:1]};
        ready_window--;
    end

    always @(posedge clk)
    begin
        if (rst_n && in_valid && in_ready)
            sb.note_char(ch);
        if (rst_n && out_valid && out_ready)
            sb.check_result(ok, address);
    end

    initial
    begin
        idle_cycles = 0;
        while (idle_cycles < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((in_valid && in_ready) || (out_valid && out_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("TB_ERROR");
        $finish;
    end

    // called at a falling edge, returns at the falling edge after acceptance
    task automatic send_char(input logic [7:0] c);
        int gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap > 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            burst_left = $urandom_range(1, 40);
        end
        in_valid <= 1'b1;
        ch       <= c;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        @(negedge clk);
        burst_left--;
        chars_sent++;
    endtask

    task automatic send_text();
        foreach (text_q[i])
            send_char(text_q[i]);
        send_char(CH_NUL);
        text_q.delete();
    endtask

    function automatic void add_str(string s);
        for (int i = 0; i < s.len(); i++)
            text_q.push_back(s[i]);
    endfunction

    task automatic send_str(string s);
        add_str(s);
        send_text();
    endtask

    function automatic logic [7:0] noise_char();
        string pool;
        pool = "0123456789abcdefxX. ";
        if ($urandom_range(0, 1) == 0)
            return pool[$urandom_range(0, pool.len() - 1)];
        return 8'($urandom_range(1, 255));
    endfunction

    // writes one part in a random radix; sometimes leaves the part empty
    function automatic void add_number(logic [63:0] v);
        string s;
        case ($urandom_range(0, 2))
            0: s = $sformatf("%0d", v);
            1:
            begin
                s = $sformatf("0%0o", v);
                if ($urandom_range(0, 7) == 0)
                    s = {s, ($urandom_range(0, 1) == 0) ? "8" : "9"};
            end
            default:
            begin
                s = $sformatf("%0h", v);
                if ($urandom_range(0, 1) == 0)
                    s = s.toupper();
                s = {($urandom_range(0, 1) == 0) ? "0x" : "0X", s};
            end
        endcase
        if ($urandom_range(0, 9) == 0)
            s = "";
        add_str(s);
    endfunction

    initial
    begin
        int          kind;
        int          nparts;
        logic [63:0] lim;
        logic [63:0] value;

        rst_n      = 1'b0;
        in_valid   = 1'b0;
        ch         = 8'd0;
        chars_sent = 0;
        burst_left = 0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        send_str("");
        send_str("0");
        send_str("255.255.255.255");
        send_str("0.0.0.0");
        send_str("4294967295");
        send_str("18446744073709551615");
        send_str("0x7f.1");
        send_str("0X1.0xFFFFFF");
        send_str("0377.00.08.9");
        send_str("0xaBcDeF01");
        send_str("1.16777216");
        send_str("1.2.65535");
        send_str("1.2.65536");
        send_str("1.2.3.256");
        send_str("1.2.3.4.5");
        send_str("256.1");
        send_str("99999999999.1");
        send_str("1..2");
        send_str("0x");
        send_str(".");
        send_str("....");
        send_str("10.0.0.1\t junk");
        send_str("1.2x");
        send_str("0xg");
        add_str("1");
        text_q.push_back(8'hFF);
        text_q.push_back(8'h80);
        send_text();

        while (chars_sent < TOTAL_CHARS)
        begin
            kind = $urandom_range(0, 9);
            if (kind < 2)
            begin
                repeat ($urandom_range(1, 10))
                    text_q.push_back(noise_char());
            end
            else
            begin
                nparts = $urandom_range(1, 5);   // five parts is one too many
                for (int p = 1; p < nparts; p++)
                begin
                    if ($urandom_range(0, 19) == 0)
                        add_number(64'($urandom_range(256, 4000)));
                    else
                        add_number(64'($urandom_range(0, 255)));
                    text_q.push_back(CH_DOT);
                end
                case (nparts)
                    1: lim = 64'hFFFF_FFFF;
                    2: lim = {32'd0, LIM_24};
                    3: lim = {32'd0, LIM_16};
                    default: lim = {32'd0, LIM_8};
                endcase
                case ($urandom_range(0, 7))
                    0: value = {$urandom, $urandom};
                    1: value = lim + 64'($urandom_range(0, 2));
                    2: value = lim - 64'($urandom_range(0, 2));
                    default: value = lim & 64'($urandom);
                endcase
                add_number(value);
                if ($urandom_range(0, 5) == 0)
                begin
                    if ($urandom_range(0, 5) == 0)
                        text_q.push_back(CH_SPACE);
                    else
                        text_q.push_back(CH_TAB + 8'($urandom_range(0, 4)));
                    repeat ($urandom_range(0, 4))
                        text_q.push_back(noise_char());
                end
                if (kind == 2 && text_q.size() > 0)
                    text_q.insert($urandom_range(0, text_q.size() - 1), noise_char());
            end
            send_text();
        end
        in_valid <= 1'b0;

        while (sb.expected_addrs.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);
        if (sb.errors == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

[files.f]
hw/rtl/ipv4tap_pkg.sv
hw/rtl/ipv4tap_mac.sv
hw/rtl/ipv4tap_step.sv
hw/rtl/ipv4_text_address_parser_unit.sv
verif/ipv4_text_address_parser_unit_tb.sv
